// File: hdl/ptcs_pkg.sv
// ----------------------------------------------------------------------------
// ptcs_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the prefix table candidate search block.
// ----------------------------------------------------------------------------
package ptcs_pkg;

   localparam int TABLE_DEPTH_DEF     = 1024;
   localparam int MAX_COMPOSITION_DEF = 6;
   localparam int MAX_CANDIDATES_DEF  = 32;
   localparam int PAGE_SIZE_DEF       = 8;

   localparam int CODE_BYTES = 6;
   localparam int BYTE_W     = 8;
   localparam int CODE_W     = CODE_BYTES * BYTE_W;
   localparam int GLYPH_W    = 24;
   localparam int ENTRY_W    = CODE_W + GLYPH_W;

   localparam int OP_W       = 4;
   localparam int LETTER_W   = 8;
   localparam int IDX_W      = 6;
   localparam int SLOT_W     = 10;
   localparam int RCOUNT_W   = 11;
   localparam int CTOTAL_W   = 6;
   localparam int PINDEX_W   = 5;
   localparam int PTOTAL_W   = 6;
   localparam int CLEN_W     = 3;

   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD         = 4'd0,
      OP_LETTER       = 4'd1,
      OP_BACKSPACE    = 4'd2,
      OP_NEXT_PAGE    = 4'd3,
      OP_PREV_PAGE    = 4'd4,
      OP_COMMIT_INDEX = 4'd5,
      OP_COMMIT_FIRST = 4'd6,
      OP_CLEAR        = 4'd7,
      OP_READ         = 4'd8
   } op_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic probe_rd;
      logic probe_upd;
      logic scan_init;
      logic scan_rd;
      logic scan_upd;
      logic cand_rd;
      logic cand_take;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic go_search;
      logic go_read;
      logic probe_more;
      logic scan_more;
      logic scan_match;
   } status_type;

endpackage

// File: hdl/prefix_table_candidate_search_top.sv
// ----------------------------------------------------------------------------
// prefix_table_candidate_search_top
// Sorted dictionary prefix search for key composition: letters build a code,
// a lower-bound search and match scan collect a paged candidate list.
//
//   port group   direction   handshake          content
//   req_*        in          valid / stall      operation and record fields
//   rsp_*        out         valid / stall      status and glyph of one op
//   csr_*        in          write enable       record_count
//
// One transaction at a time. A search edit runs lower-bound binary search
// probes and then a match scan; probes are about log2(record_count) + 1,
// matches at most MAX_CANDIDATES, and each probe or scan step reads the
// single registered read port of the dictionary memory. Candidate commit
// or read fetches its entry through the same port. A new transaction is
// taken while the previous result waits in the output register. Reset is
// synchronous and empties composition and candidates; dictionary contents are not cleared.
// ----------------------------------------------------------------------------
module prefix_table_candidate_search_top #(
   parameter int TABLE_DEPTH     = ptcs_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_COMPOSITION = ptcs_pkg::MAX_COMPOSITION_DEF,
   parameter int MAX_CANDIDATES  = ptcs_pkg::MAX_CANDIDATES_DEF,
   parameter int PAGE_SIZE       = ptcs_pkg::PAGE_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ptcs_pkg::OP_W-1:0]       req_operation,
   input  logic [ptcs_pkg::LETTER_W-1:0]   req_letter,
   input  logic [ptcs_pkg::IDX_W-1:0]      req_cand_index,
   input  logic [ptcs_pkg::SLOT_W-1:0]     req_record_slot,
   input  logic [ptcs_pkg::CODE_W-1:0]     req_record_code,
   input  logic [ptcs_pkg::GLYPH_W-1:0]    req_record_hanzi,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_accepted,
   output logic [ptcs_pkg::GLYPH_W-1:0]    rsp_hanzi,
   output logic [ptcs_pkg::CTOTAL_W-1:0]   rsp_candidate_total,
   output logic [ptcs_pkg::PINDEX_W-1:0]   rsp_page_index,
   output logic [ptcs_pkg::PTOTAL_W-1:0]   rsp_page_total,
   output logic [ptcs_pkg::CLEN_W-1:0]     rsp_composed_length,
   input  logic                            csr_wr_en,
   input  logic [ptcs_pkg::RCOUNT_W-1:0]   csr_wr_data
);

   ptcs_pkg::cmd_type    cmd;
   ptcs_pkg::status_type status;

   ptcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ptcs_datapath #(
      .TABLE_DEPTH     (TABLE_DEPTH),
      .MAX_COMPOSITION (MAX_COMPOSITION),
      .MAX_CANDIDATES  (MAX_CANDIDATES),
      .PAGE_SIZE       (PAGE_SIZE)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_operation),
      .req_letter          (req_letter),
      .req_cand_index      (req_cand_index),
      .req_record_slot     (req_record_slot),
      .req_record_code     (req_record_code),
      .req_record_hanzi    (req_record_hanzi),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_accepted        (rsp_accepted),
      .rsp_hanzi           (rsp_hanzi),
      .rsp_candidate_total (rsp_candidate_total),
      .rsp_page_index      (rsp_page_index),
      .rsp_page_total      (rsp_page_total),
      .rsp_composed_length (rsp_composed_length)
   );

endmodule

// File: hdl/ptcs_ctrl.sv
// ----------------------------------------------------------------------------
// ptcs_ctrl
// Sequencer: takes one transaction, runs the edit, binary search probes,
// match scan or candidate read, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ptcs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  ptcs_pkg::status_type  status,
   output ptcs_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_PROBE_RD,
      S_PROBE_CMP,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_CAND_RD,
      S_CAND_CMP,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_stall_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (status.go_search) begin
               state_in = S_PROBE_RD;
            end else if (status.go_read) begin
               state_in = S_CAND_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PROBE_RD: begin
            if (status.probe_more) begin
               cmd.probe_rd = 1'b1;
               state_in     = S_PROBE_CMP;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_PROBE_CMP: begin
            cmd.probe_upd = 1'b1;
            state_in      = S_PROBE_RD;
         end
         S_SCAN_RD: begin
            if (status.scan_more) begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_CMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN_CMP: begin
            cmd.scan_upd = 1'b1;
            state_in     = status.scan_match ? S_SCAN_RD : S_DONE;
         end
         S_CAND_RD: begin
            cmd.cand_rd = 1'b1;
            state_in    = S_CAND_CMP;
         end
         S_CAND_CMP: begin
            cmd.cand_take = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_IDLE);
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/ptcs_datapath.sv
// ----------------------------------------------------------------------------
// ptcs_datapath
// Dictionary memory, composition and candidate state, binary search bounds,
// match scan counters and the result register.
// ----------------------------------------------------------------------------
module ptcs_datapath #(
   parameter int TABLE_DEPTH     = ptcs_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_COMPOSITION = ptcs_pkg::MAX_COMPOSITION_DEF,
   parameter int MAX_CANDIDATES  = ptcs_pkg::MAX_CANDIDATES_DEF,
   parameter int PAGE_SIZE       = ptcs_pkg::PAGE_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ptcs_pkg::cmd_type               cmd,
   output ptcs_pkg::status_type            status,
   input  logic [ptcs_pkg::OP_W-1:0]       req_operation,
   input  logic [ptcs_pkg::LETTER_W-1:0]   req_letter,
   input  logic [ptcs_pkg::IDX_W-1:0]      req_cand_index,
   input  logic [ptcs_pkg::SLOT_W-1:0]     req_record_slot,
   input  logic [ptcs_pkg::CODE_W-1:0]     req_record_code,
   input  logic [ptcs_pkg::GLYPH_W-1:0]    req_record_hanzi,
   input  logic                            csr_wr_en,
   input  logic [ptcs_pkg::RCOUNT_W-1:0]   csr_wr_data,
   output logic                            rsp_accepted,
   output logic [ptcs_pkg::GLYPH_W-1:0]    rsp_hanzi,
   output logic [ptcs_pkg::CTOTAL_W-1:0]   rsp_candidate_total,
   output logic [ptcs_pkg::PINDEX_W-1:0]   rsp_page_index,
   output logic [ptcs_pkg::PTOTAL_W-1:0]   rsp_page_total,
   output logic [ptcs_pkg::CLEN_W-1:0]     rsp_composed_length
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int RW    = $clog2(MAX_CANDIDATES + 1);
   localparam int MAXPG = (MAX_CANDIDATES + PAGE_SIZE - 1) / PAGE_SIZE;
   localparam int PGW   = (MAXPG > 1) ? $clog2(MAXPG) : 1;
   localparam int PTW   = $clog2(MAXPG + 1);
   localparam int PSW   = $clog2(PAGE_SIZE + 1);
   localparam int POSW  = PGW + PSW;
   localparam int PW0   = (POSW > RW) ? POSW : RW;
   localparam int PW    = ((PW0 > ptcs_pkg::IDX_W) ? PW0 : ptcs_pkg::IDX_W) + 1;
   localparam int EW0   = (CW > ptcs_pkg::RCOUNT_W) ? CW : ptcs_pkg::RCOUNT_W;
   localparam int EW    = ((EW0 > ptcs_pkg::SLOT_W) ? EW0 : ptcs_pkg::SLOT_W) + 1;
   localparam int BW    = ptcs_pkg::BYTE_W;
   localparam int NB    = ptcs_pkg::CODE_BYTES;
   localparam int GW    = ptcs_pkg::GLYPH_W;

   logic [ptcs_pkg::ENTRY_W-1:0]  mem [TABLE_DEPTH];
   logic [ptcs_pkg::ENTRY_W-1:0]  rd_ff;
   logic [AW-1:0]                 rd_addr;
   logic                          rd_en;

   logic [ptcs_pkg::OP_W-1:0]     op_ff;
   logic [ptcs_pkg::LETTER_W-1:0] letter_ff;
   logic [ptcs_pkg::IDX_W-1:0]    idx_ff;
   logic [ptcs_pkg::SLOT_W-1:0]   slot_ff;
   logic [ptcs_pkg::CODE_W-1:0]   code_ff;
   logic [GW-1:0]                 glyph_ff;
   logic [ptcs_pkg::RCOUNT_W-1:0] rcount_ff;

   logic [ptcs_pkg::CODE_W-1:0]   comp_ff,      comp_in;
   logic [ptcs_pkg::CLEN_W-1:0]   len_ff,       len_in;
   logic [CW-1:0]                 run_start_ff, run_start_in;
   logic [RW-1:0]                 run_ff,       run_in;
   logic [PGW-1:0]                page_ff,      page_in;
   logic [PTW-1:0]                pages_ff,     pages_in;
   logic [PSW-1:0]                fill_ff,      fill_in;
   logic [CW-1:0]                 lo_ff,        lo_in;
   logic [CW-1:0]                 hi_ff,        hi_in;
   logic [CW-1:0]                 cnt_ff,       cnt_in;
   logic [CW-1:0]                 scan_ff,      scan_in;
   logic                          acc_ff,       acc_in;
   logic [GW-1:0]                 hanzi_ff,     hanzi_in;

   logic                          out_acc_ff;
   logic [GW-1:0]                 out_hanzi_ff;
   logic [ptcs_pkg::CTOTAL_W-1:0] out_total_ff;
   logic [ptcs_pkg::PINDEX_W-1:0] out_page_ff;
   logic [ptcs_pkg::PTOTAL_W-1:0] out_pages_ff;
   logic [ptcs_pkg::CLEN_W-1:0]   out_len_ff;

   logic [BW-1:0]                 ch;
   logic                          letter_ok;
   logic                          load_ok;
   logic                          next_ok;
   logic [PW-1:0]                 pos;
   logic                          pos_ok;
   logic                          is_pick;
   logic [EW-1:0]                 rcount_ext;
   logic [CW-1:0]                 count_clamp;
   logic [CW-1:0]                 cnt_new;
   logic [CW-1:0]                 mid;
   logic [ptcs_pkg::CODE_W-1:0]   code_mask;
   logic [ptcs_pkg::CODE_W-1:0]   code_masked;
   logic [ptcs_pkg::CODE_W-1:0]   comp_app;
   logic [ptcs_pkg::CODE_W-1:0]   comp_del;
   logic                          code_less;
   logic                          code_match;
   logic [CW+PW-1:0]              cand_sum;

   // request decode
   always_comb begin
      ch = req_letter_fold(letter_ff);
      letter_ok = (ch >= ptcs_pkg::CHAR_LOWER_A) && (ch <= ptcs_pkg::CHAR_LOWER_Z)
                  && (32'(len_ff) < MAX_COMPOSITION);
      load_ok = (32'(slot_ff) < TABLE_DEPTH);
      next_ok = (PTW'(page_ff) + PTW'(1)) < pages_ff;
      if (op_ff == ptcs_pkg::OP_COMMIT_FIRST) begin
         pos = PW'(PW'(page_ff) * PW'(PAGE_SIZE));
      end else begin
         pos = PW'(idx_ff);
      end
      pos_ok  = pos < PW'(run_ff);
      is_pick = (op_ff == ptcs_pkg::OP_COMMIT_INDEX) || (op_ff == ptcs_pkg::OP_COMMIT_FIRST)
                || (op_ff == ptcs_pkg::OP_READ);
      rcount_ext = EW'(rcount_ff);
      if (rcount_ext > EW'(TABLE_DEPTH)) begin
         count_clamp = CW'(TABLE_DEPTH);
      end else begin
         count_clamp = CW'(rcount_ext);
      end
      if ((op_ff == ptcs_pkg::OP_BACKSPACE) && (len_ff == ptcs_pkg::CLEN_W'(1))) begin
         cnt_new = '0;
      end else begin
         cnt_new = count_clamp;
      end
   end

   function automatic logic [BW-1:0] req_letter_fold(input logic [BW-1:0] c);
      logic [BW-1:0] r;
      r = c;
      if ((c >= ptcs_pkg::CHAR_UPPER_A) && (c <= ptcs_pkg::CHAR_UPPER_Z)) begin
         r = c + ptcs_pkg::CASE_OFFSET;
      end
      return r;
   endfunction

   // composition edits and prefix compare
   always_comb begin
      comp_app = comp_ff;
      comp_del = comp_ff;
      for (int k = 0; k < NB; k++) begin
         code_mask[ptcs_pkg::CODE_W-1-BW*k -: BW] = (k < 32'(len_ff)) ? '1 : '0;
         if (k == 32'(len_ff)) begin
            comp_app[ptcs_pkg::CODE_W-1-BW*k -: BW] = ch;
         end
         if (k + 1 == 32'(len_ff)) begin
            comp_del[ptcs_pkg::CODE_W-1-BW*k -: BW] = '0;
         end
      end
      code_masked = rd_ff[ptcs_pkg::ENTRY_W-1 -: ptcs_pkg::CODE_W] & code_mask;
      code_less   = code_masked < comp_ff;
      code_match  = code_masked == comp_ff;
   end

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign cand_sum = (CW+PW)'(run_start_ff) + (CW+PW)'(pos);

   always_comb begin
      status.go_search  = ((op_ff == ptcs_pkg::OP_LETTER) && letter_ok)
                          || ((op_ff == ptcs_pkg::OP_BACKSPACE) && (len_ff != '0));
      status.go_read    = is_pick && pos_ok;
      status.probe_more = lo_ff < hi_ff;
      status.scan_more  = (scan_ff < cnt_ff) && (32'(run_ff) < MAX_CANDIDATES);
      status.scan_match = code_match;
   end

   // memory
   always_comb begin
      rd_en = cmd.probe_rd | cmd.scan_rd | cmd.cand_rd;
      if (cmd.probe_rd) begin
         rd_addr = AW'(mid);
      end else if (cmd.scan_rd) begin
         rd_addr = AW'(scan_ff);
      end else begin
         rd_addr = AW'(cand_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && (op_ff == ptcs_pkg::OP_LOAD) && load_ok) begin
         mem[AW'(slot_ff)] <= {code_ff, glyph_ff};
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // state update
   always_comb begin
      comp_in      = comp_ff;
      len_in       = len_ff;
      run_start_in = run_start_ff;
      run_in       = run_ff;
      page_in      = page_ff;
      pages_in     = pages_ff;
      fill_in      = fill_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cnt_in       = cnt_ff;
      scan_in      = scan_ff;
      acc_in       = acc_ff;
      hanzi_in     = hanzi_ff;

      if (cmd.exec) begin
         acc_in   = 1'b0;
         hanzi_in = '0;
         case (op_ff)
            ptcs_pkg::OP_LOAD: begin
               acc_in = load_ok;
            end
            ptcs_pkg::OP_LETTER: begin
               if (letter_ok) begin
                  comp_in = comp_app;
                  len_in  = len_ff + ptcs_pkg::CLEN_W'(1);
                  acc_in  = 1'b1;
               end
            end
            ptcs_pkg::OP_BACKSPACE: begin
               if (len_ff != '0) begin
                  comp_in = comp_del;
                  len_in  = len_ff - ptcs_pkg::CLEN_W'(1);
                  acc_in  = 1'b1;
               end
            end
            ptcs_pkg::OP_NEXT_PAGE: begin
               if (next_ok) begin
                  page_in = page_ff + PGW'(1);
                  acc_in  = 1'b1;
               end
            end
            ptcs_pkg::OP_PREV_PAGE: begin
               if (page_ff != '0) begin
                  page_in = page_ff - PGW'(1);
                  acc_in  = 1'b1;
               end
            end
            ptcs_pkg::OP_COMMIT_INDEX, ptcs_pkg::OP_COMMIT_FIRST, ptcs_pkg::OP_READ: begin
               acc_in = pos_ok;
            end
            ptcs_pkg::OP_CLEAR: begin
               comp_in      = '0;
               len_in       = '0;
               run_start_in = '0;
               run_in       = '0;
               page_in      = '0;
               pages_in     = '0;
               fill_in      = '0;
               acc_in       = 1'b1;
            end
            default: begin
               acc_in = 1'b0;
            end
         endcase
         if (status.go_search) begin
            lo_in        = '0;
            hi_in        = cnt_new;
            cnt_in       = cnt_new;
            run_start_in = '0;
            run_in       = '0;
            page_in      = '0;
            pages_in     = '0;
            fill_in      = '0;
         end
      end

      if (cmd.probe_upd) begin
         if (code_less) begin
            lo_in = mid + CW'(1);
         end else begin
            hi_in = mid;
         end
      end

      if (cmd.scan_init) begin
         run_start_in = lo_ff;
         scan_in      = lo_ff;
      end

      // pages tracked incrementally: a new page opens each PAGE_SIZE matches
      if (cmd.scan_upd && code_match) begin
         run_in  = run_ff + RW'(1);
         scan_in = scan_ff + CW'(1);
         if (fill_ff == '0) begin
            pages_in = pages_ff + PTW'(1);
         end
         if (32'(fill_ff) == PAGE_SIZE - 1) begin
            fill_in = '0;
         end else begin
            fill_in = fill_ff + PSW'(1);
         end
      end

      if (cmd.cand_take) begin
         hanzi_in = rd_ff[GW-1:0];
         if (op_ff != ptcs_pkg::OP_READ) begin
            comp_in      = '0;
            len_in       = '0;
            run_start_in = '0;
            run_in       = '0;
            page_in      = '0;
            pages_in     = '0;
            fill_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rcount_ff    <= '0;
         comp_ff      <= '0;
         len_ff       <= '0;
         run_start_ff <= '0;
         run_ff       <= '0;
         page_ff      <= '0;
         pages_ff     <= '0;
         fill_ff      <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         cnt_ff       <= '0;
         scan_ff      <= '0;
         acc_ff       <= 1'b0;
         hanzi_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            rcount_ff <= csr_wr_data;
         end
         comp_ff      <= comp_in;
         len_ff       <= len_in;
         run_start_ff <= run_start_in;
         run_ff       <= run_in;
         page_ff      <= page_in;
         pages_ff     <= pages_in;
         fill_ff      <= fill_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         cnt_ff       <= cnt_in;
         scan_ff      <= scan_in;
         acc_ff       <= acc_in;
         hanzi_ff     <= hanzi_in;
      end
   end

   // request capture and result register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         letter_ff <= req_letter;
         idx_ff    <= req_cand_index;
         slot_ff   <= req_record_slot;
         code_ff   <= req_record_code;
         glyph_ff  <= req_record_hanzi;
      end
      if (cmd.rsp_load) begin
         out_acc_ff   <= acc_ff;
         out_hanzi_ff <= hanzi_ff;
         out_total_ff <= ptcs_pkg::CTOTAL_W'(run_ff);
         out_page_ff  <= ptcs_pkg::PINDEX_W'(page_ff);
         out_pages_ff <= ptcs_pkg::PTOTAL_W'(pages_ff);
         out_len_ff   <= len_ff;
      end
   end

   assign rsp_accepted        = out_acc_ff;
   assign rsp_hanzi           = out_hanzi_ff;
   assign rsp_candidate_total = out_total_ff;
   assign rsp_page_index      = out_page_ff;
   assign rsp_page_total      = out_pages_ff;
   assign rsp_composed_length = out_len_ff;

endmodule
